[src/mec_pkg.sv]
// Package for the mesh edge classifier: field widths, stage payload types,
// register indexes and edge kind codes. No dependencies.
`default_nettype none

package mec_pkg;

  localparam int ID_W       = 16;
  localparam int FACE_W     = 16;
  localparam int NORM_W     = 16;
  localparam int POS_W      = 20;
  localparam int VIEW_W     = POS_W + 1;
  localparam int CC_W       = 16;
  localparam int CC_SHIFT   = 15;
  localparam int NPROD_W    = 2 * NORM_W;
  localparam int VPROD_W    = VIEW_W + NORM_W;
  localparam int NDOT_W     = NPROD_W + 2;
  localparam int VDOT_W     = VPROD_W + 2;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [FACE_W-1:0] EMPTY_FACE_RESET = '1;

  typedef enum logic [KIND_W-1:0] {
    KIND_BOUNDARY   = 2'd0,
    KIND_CREASE     = 2'd1,
    KIND_SILHOUETTE = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EYE_X         = 3'd0,
    REG_EYE_Y         = 3'd1,
    REG_EYE_Z         = 3'd2,
    REG_CREASE_COSINE = 3'd3,
    REG_EMPTY_FACE    = 3'd4
  } reg_idx_t;

  // After the front stage: view vector formed, boundary test done.
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic              boundary;
    logic [NORM_W-1:0] na_x;
    logic [NORM_W-1:0] na_y;
    logic [NORM_W-1:0] na_z;
    logic [NORM_W-1:0] nb_x;
    logic [NORM_W-1:0] nb_y;
    logic [NORM_W-1:0] nb_z;
    logic [VIEW_W-1:0] view_x;
    logic [VIEW_W-1:0] view_y;
    logic [VIEW_W-1:0] view_z;
  } s1_t;

  // After the multiplier stage: all nine partial products.
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic               boundary;
    logic [NPROD_W-1:0] nn_x;
    logic [NPROD_W-1:0] nn_y;
    logic [NPROD_W-1:0] nn_z;
    logic [VPROD_W-1:0] va_x;
    logic [VPROD_W-1:0] va_y;
    logic [VPROD_W-1:0] va_z;
    logic [VPROD_W-1:0] vb_x;
    logic [VPROD_W-1:0] vb_y;
    logic [VPROD_W-1:0] vb_z;
  } s2_t;

  // After the adder stage: the three dot products.
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic              boundary;
    logic [NDOT_W-1:0] nd;
    logic [VDOT_W-1:0] d1;
    logic [VDOT_W-1:0] d2;
  } s3_t;

endpackage

`default_nettype wire

[src/mec_front.sv]
// Front stage of the mesh edge classifier: registers the input transaction,
// forms the view vector and runs the boundary test. Depends on mec_pkg.
`default_nettype none

module mec_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [mec_pkg::ID_W-1:0]       edge_id,
  input  wire logic [mec_pkg::FACE_W-1:0]     face_a_index,
  input  wire logic [mec_pkg::FACE_W-1:0]     face_b_index,
  input  wire logic signed [mec_pkg::NORM_W-1:0] normal_a_x,
  input  wire logic signed [mec_pkg::NORM_W-1:0] normal_a_y,
  input  wire logic signed [mec_pkg::NORM_W-1:0] normal_a_z,
  input  wire logic signed [mec_pkg::NORM_W-1:0] normal_b_x,
  input  wire logic signed [mec_pkg::NORM_W-1:0] normal_b_y,
  input  wire logic signed [mec_pkg::NORM_W-1:0] normal_b_z,
  input  wire logic signed [mec_pkg::POS_W-1:0]  edge_vertex_x,
  input  wire logic signed [mec_pkg::POS_W-1:0]  edge_vertex_y,
  input  wire logic signed [mec_pkg::POS_W-1:0]  edge_vertex_z,
  input  wire logic signed [mec_pkg::POS_W-1:0]  eye_x,
  input  wire logic signed [mec_pkg::POS_W-1:0]  eye_y,
  input  wire logic signed [mec_pkg::POS_W-1:0]  eye_z,
  input  wire logic [mec_pkg::FACE_W-1:0]     empty_face_code,
  output mec_pkg::s1_t                        s1,
  output logic                                s1_valid,
  input  wire logic                           s1_ready
);

  mec_pkg::s1_t s1_next;

  assign in_ready = !s1_valid || s1_ready;

  always_comb begin
    s1_next          = s1;
    s1_next.id       = edge_id;
    s1_next.boundary = (face_a_index == face_b_index) ||
                       (face_a_index == empty_face_code) ||
                       (face_b_index == empty_face_code);
    s1_next.na_x     = normal_a_x;
    s1_next.na_y     = normal_a_y;
    s1_next.na_z     = normal_a_z;
    s1_next.nb_x     = normal_b_x;
    s1_next.nb_y     = normal_b_y;
    s1_next.nb_z     = normal_b_z;
    s1_next.view_x   = mec_pkg::VIEW_W'(eye_x) - mec_pkg::VIEW_W'(edge_vertex_x);
    s1_next.view_y   = mec_pkg::VIEW_W'(eye_y) - mec_pkg::VIEW_W'(edge_vertex_y);
    s1_next.view_z   = mec_pkg::VIEW_W'(eye_z) - mec_pkg::VIEW_W'(edge_vertex_z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1 <= s1_next;
    end
  end

endmodule

`default_nettype wire

[src/mec_mult.sv]
// Multiplier stage of the mesh edge classifier: the normal-normal and
// view-normal products, one register stage. Depends on mec_pkg.
`default_nettype none

module mec_mult (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire mec_pkg::s1_t s1,
  input  wire logic   s1_valid,
  output logic        s1_ready,
  output mec_pkg::s2_t s2,
  output logic        s2_valid,
  input  wire logic   s2_ready
);

  mec_pkg::s2_t s2_next;

  logic signed [mec_pkg::NPROD_W-1:0] nn_x, nn_y, nn_z;
  logic signed [mec_pkg::VPROD_W-1:0] va_x, va_y, va_z;
  logic signed [mec_pkg::VPROD_W-1:0] vb_x, vb_y, vb_z;

  assign s1_ready = !s2_valid || s2_ready;

  // All operands are signed, so each is sign-extended to the product width.
  always_comb begin
    nn_x = $signed(s1.na_x) * $signed(s1.nb_x);
    nn_y = $signed(s1.na_y) * $signed(s1.nb_y);
    nn_z = $signed(s1.na_z) * $signed(s1.nb_z);
    va_x = $signed(s1.view_x) * $signed(s1.na_x);
    va_y = $signed(s1.view_y) * $signed(s1.na_y);
    va_z = $signed(s1.view_z) * $signed(s1.na_z);
    vb_x = $signed(s1.view_x) * $signed(s1.nb_x);
    vb_y = $signed(s1.view_y) * $signed(s1.nb_y);
    vb_z = $signed(s1.view_z) * $signed(s1.nb_z);

    s2_next          = s2;
    s2_next.id       = s1.id;
    s2_next.boundary = s1.boundary;
    s2_next.nn_x     = nn_x;
    s2_next.nn_y     = nn_y;
    s2_next.nn_z     = nn_z;
    s2_next.va_x     = va_x;
    s2_next.va_y     = va_y;
    s2_next.va_z     = va_z;
    s2_next.vb_x     = vb_x;
    s2_next.vb_y     = vb_y;
    s2_next.vb_z     = vb_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && s1_valid) begin
      s2 <= s2_next;
    end
  end

endmodule

`default_nettype wire

[src/mec_decide.sv]
// Back end of the mesh edge classifier: sums the products into dot products,
// then tests crease and silhouette and fills the output register.
// Depends on mec_pkg.
`default_nettype none

module mec_decide (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire mec_pkg::s2_t                 s2,
  input  wire logic                         s2_valid,
  output logic                              s2_ready,
  input  wire logic signed [mec_pkg::CC_W-1:0] crease_cosine,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [mec_pkg::ID_W-1:0]          found_edge_id,
  output logic [mec_pkg::KIND_W-1:0]        edge_kind
);

  mec_pkg::s3_t  s3;
  mec_pkg::s3_t  s3_next;
  logic          s3_valid;
  logic          s3_ready;

  logic signed [mec_pkg::NDOT_W-1:0] nd_sum;
  logic signed [mec_pkg::VDOT_W-1:0] d1_sum, d2_sum;
  logic signed [mec_pkg::NDOT_W-1:0] threshold;
  logic          crease;
  logic          silhouette;
  logic          keep;
  mec_pkg::kind_t kind_next;

  assign s2_ready = !s3_valid || s3_ready;
  assign s3_ready = !out_valid || out_ready;

  always_comb begin
    nd_sum = $signed(s2.nn_x) + $signed(s2.nn_y) + $signed(s2.nn_z);
    d1_sum = $signed(s2.va_x) + $signed(s2.va_y) + $signed(s2.va_z);
    d2_sum = $signed(s2.vb_x) + $signed(s2.vb_y) + $signed(s2.vb_z);

    s3_next          = s3;
    s3_next.id       = s2.id;
    s3_next.boundary = s2.boundary;
    s3_next.nd       = nd_sum;
    s3_next.d1       = d1_sum;
    s3_next.d2       = d2_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s2_ready) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s2_valid) begin
      s3 <= s3_next;
    end
  end

  // The crease cosine is Q1.15 and the normal dot product Q4.30.
  assign threshold = {{(mec_pkg::NDOT_W - mec_pkg::CC_W - mec_pkg::CC_SHIFT)
                       {crease_cosine[mec_pkg::CC_W-1]}},
                      crease_cosine, {mec_pkg::CC_SHIFT{1'b0}}};

  always_comb begin
    crease     = $signed(s3.nd) <= threshold;
    // The product of the two signs is at most zero when either is zero or
    // the signs differ.
    silhouette = (s3.d1 == '0) || (s3.d2 == '0) ||
                 (s3.d1[mec_pkg::VDOT_W-1] != s3.d2[mec_pkg::VDOT_W-1]);
    keep       = s3.boundary || crease || silhouette;
    if (s3.boundary) begin
      kind_next = mec_pkg::KIND_BOUNDARY;
    end else if (crease) begin
      kind_next = mec_pkg::KIND_CREASE;
    end else begin
      kind_next = mec_pkg::KIND_SILHOUETTE;
    end
  end

  // Edges that match no test are dropped here and leave a bubble.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s3_ready) begin
      out_valid <= s3_valid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s3_valid) begin
      found_edge_id <= s3.id;
      edge_kind     <= kind_next;
    end
  end

  a_boundary_first: assert property (@(posedge clk) disable iff (rst)
    (s3_valid && s3_ready && s3.boundary) |=>
      (out_valid && edge_kind == mec_pkg::KIND_BOUNDARY))
    else $error("boundary edge not emitted as boundary");

  a_zero_view_dot: assert property (@(posedge clk) disable iff (rst)
    (s3_valid && s3_ready && s3.d1 == '0) |=> out_valid)
    else $error("edge with zero view dot product was dropped");

  a_drop_needs_miss: assert property (@(posedge clk) disable iff (rst)
    (s3_valid && s3_ready && !s3.boundary && !crease && !silhouette) |=> !out_valid)
    else $error("edge matching no test was emitted");

endmodule

`default_nettype wire

[src/mesh_edge_classifier.sv]
// Mesh edge classifier top level: configuration registers and the stages.
// The input transaction passes through four register stages, front, multiply,
// add and decide; one edge is accepted every cycle unless back-pressure from
// out_ready stalls the pipeline. Edges matching no test produce no result.
// Synchronous reset clears all valid bits and loads the register reset values.
`default_nettype none

module mesh_edge_classifier (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [mec_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [mec_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [mec_pkg::ID_W-1:0]           edge_id,
  input  wire logic [mec_pkg::FACE_W-1:0]         face_a_index,
  input  wire logic [mec_pkg::FACE_W-1:0]         face_b_index,
  input  wire logic signed [mec_pkg::NORM_W-1:0]  normal_a_x,
  input  wire logic signed [mec_pkg::NORM_W-1:0]  normal_a_y,
  input  wire logic signed [mec_pkg::NORM_W-1:0]  normal_a_z,
  input  wire logic signed [mec_pkg::NORM_W-1:0]  normal_b_x,
  input  wire logic signed [mec_pkg::NORM_W-1:0]  normal_b_y,
  input  wire logic signed [mec_pkg::NORM_W-1:0]  normal_b_z,
  input  wire logic signed [mec_pkg::POS_W-1:0]   edge_vertex_x,
  input  wire logic signed [mec_pkg::POS_W-1:0]   edge_vertex_y,
  input  wire logic signed [mec_pkg::POS_W-1:0]   edge_vertex_z,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [mec_pkg::ID_W-1:0]                found_edge_id,
  output logic [mec_pkg::KIND_W-1:0]              edge_kind
);

  logic signed [mec_pkg::POS_W-1:0] eye_x;
  logic signed [mec_pkg::POS_W-1:0] eye_y;
  logic signed [mec_pkg::POS_W-1:0] eye_z;
  logic signed [mec_pkg::CC_W-1:0]  crease_cosine;
  logic [mec_pkg::FACE_W-1:0]       empty_face_code;

  mec_pkg::s1_t s1;
  logic         s1_valid;
  logic         s1_ready;
  mec_pkg::s2_t s2;
  logic         s2_valid;
  logic         s2_ready;

  // Writes to indexes beyond the register list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      eye_x           <= '0;
      eye_y           <= '0;
      eye_z           <= '0;
      crease_cosine   <= '0;
      empty_face_code <= mec_pkg::EMPTY_FACE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mec_pkg::REG_EYE_X:         eye_x <= cfg_data[mec_pkg::POS_W-1:0];
        mec_pkg::REG_EYE_Y:         eye_y <= cfg_data[mec_pkg::POS_W-1:0];
        mec_pkg::REG_EYE_Z:         eye_z <= cfg_data[mec_pkg::POS_W-1:0];
        mec_pkg::REG_CREASE_COSINE: crease_cosine <= cfg_data[mec_pkg::CC_W-1:0];
        mec_pkg::REG_EMPTY_FACE:    empty_face_code <= cfg_data[mec_pkg::FACE_W-1:0];
        default: ;
      endcase
    end
  end

  mec_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .edge_id         (edge_id),
    .face_a_index    (face_a_index),
    .face_b_index    (face_b_index),
    .normal_a_x      (normal_a_x),
    .normal_a_y      (normal_a_y),
    .normal_a_z      (normal_a_z),
    .normal_b_x      (normal_b_x),
    .normal_b_y      (normal_b_y),
    .normal_b_z      (normal_b_z),
    .edge_vertex_x   (edge_vertex_x),
    .edge_vertex_y   (edge_vertex_y),
    .edge_vertex_z   (edge_vertex_z),
    .eye_x           (eye_x),
    .eye_y           (eye_y),
    .eye_z           (eye_z),
    .empty_face_code (empty_face_code),
    .s1              (s1),
    .s1_valid        (s1_valid),
    .s1_ready        (s1_ready)
  );

  mec_mult u_mult (
    .clk      (clk),
    .rst      (rst),
    .s1       (s1),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s2       (s2),
    .s2_valid (s2_valid),
    .s2_ready (s2_ready)
  );

  mec_decide u_decide (
    .clk           (clk),
    .rst           (rst),
    .s2            (s2),
    .s2_valid      (s2_valid),
    .s2_ready      (s2_ready),
    .crease_cosine (crease_cosine),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .found_edge_id (found_edge_id),
    .edge_kind     (edge_kind)
  );

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (!out_valid && in_ready))
    else $error("pipeline not empty after reset");

  // Back-pressure only starts at a held result, so a refused input means
  // every stage is full.
  a_stall_origin: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready && s1_valid && s2_valid))
    else $error("input refused while the pipeline has room");

  a_empty_code_write: assert property (@(posedge clk) disable iff (rst)
    (cfg_we && cfg_index == mec_pkg::REG_EMPTY_FACE) |=>
      (empty_face_code == $past(cfg_data[mec_pkg::FACE_W-1:0])))
    else $error("empty face code write lost");

endmodule

`default_nettype wire
